// ----- rtl/dtf_pkg.sv -----
// Shared constants and types for the degenerate triangle filter.
package dtf_pkg;

    localparam int IDX_WIDTH       = 25;
    localparam int NUM_IDX         = 3;
    localparam int NUM_COORD       = 9;
    localparam int NUM_EDGE        = 6;
    localparam int THR_WIDTH       = 64;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int OUT_TDATA_WIDTH = 8;

    // Register stages from accept to the output register.
    localparam int NUM_STAGES = 9;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VERTEX_COUNT   = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AREA_THRESHOLD = 8'd1;

    localparam logic [IDX_WIDTH-1:0] VERTEX_COUNT_RESET   = 25'd0;
    localparam logic [THR_WIDTH-1:0] AREA_THRESHOLD_RESET = 64'd184467;

    typedef logic [1:0] reason_t;

    localparam reason_t REASON_KEEP   = 2'd0;
    localparam reason_t REASON_REPEAT = 2'd1;
    localparam reason_t REASON_RANGE  = 2'd2;
    localparam reason_t REASON_AREA   = 2'd3;

    typedef struct packed {
        logic repeated;
        logic out_of_range;
    } idx_status_t;

endpackage

// ----- rtl/dtf_umul.sv -----
// Two-stage unsigned multiplier built from four half-width partial products.
module dtf_umul #(
    parameter int W = 32
) (
    input  logic             clk,
    input  logic             en_pp,
    input  logic             en_sum,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [2*W-1:0]   p
);

    localparam int LW = (W + 1) / 2;
    localparam int HW = W - LW;

    logic [2*LW-1:0]  ll_reg;
    logic [W-1:0]     lh_reg;
    logic [W-1:0]     hl_reg;
    logic [2*HW-1:0]  hh_reg;
    logic [2*W-1:0]   p_reg;
    logic [2*W-1:0]   p_next;

    always_ff @(posedge clk)
    begin
        if (en_pp)
        begin
            ll_reg <= a[LW-1:0] * b[LW-1:0];
            lh_reg <= a[LW-1:0] * b[W-1:LW];
            hl_reg <= a[W-1:LW] * b[LW-1:0];
            hh_reg <= a[W-1:LW] * b[W-1:LW];
        end
    end

    always_comb
    begin
        p_next = {{(2*HW){1'b0}}, ll_reg}
               + ({{W{1'b0}}, lh_reg} << LW)
               + ({{W{1'b0}}, hl_reg} << LW)
               + ({{(2*LW){1'b0}}, hh_reg} << (2 * LW));
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/dtf_idx_check.sv -----
// Vertex index checks: repeated index and negative or out-of-range index.
module dtf_idx_check (
    input  logic [dtf_pkg::IDX_WIDTH-1:0] index_a,
    input  logic [dtf_pkg::IDX_WIDTH-1:0] index_b,
    input  logic [dtf_pkg::IDX_WIDTH-1:0] index_c,
    input  logic [dtf_pkg::IDX_WIDTH-1:0] vertex_count,
    output dtf_pkg::idx_status_t          status
);

    logic neg_any;
    logic high_any;

    always_comb
    begin
        status.repeated = (index_a == index_b) || (index_b == index_c)
                        || (index_a == index_c);
        neg_any  = index_a[dtf_pkg::IDX_WIDTH-1] | index_b[dtf_pkg::IDX_WIDTH-1]
                 | index_c[dtf_pkg::IDX_WIDTH-1];
        high_any = (index_a >= vertex_count) || (index_b >= vertex_count)
                 || (index_c >= vertex_count);
        status.out_of_range = neg_any | high_any;
    end

endmodule

// ----- rtl/dtf_cross.sv -----
// Squared magnitude of the edge cross product, exact, over seven register stages.
module dtf_cross #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              clk,
    // Load enables for stages two through eight, lowest bit first.
    input  logic [6:0]                        en,
    input  logic [COORD_WIDTH-1:0]            mag [dtf_pkg::NUM_EDGE],
    input  logic [dtf_pkg::NUM_EDGE-1:0]      neg,
    output logic [4*COORD_WIDTH+3:0]          sum
);

    localparam int PW   = 2 * COORD_WIDTH;
    localparam int DSW  = PW + 2;
    localparam int MW   = PW + 1;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = 4 * COORD_WIDTH + 4;

    localparam int EN_PP     = 0;
    localparam int EN_PROD   = 1;
    localparam int EN_DIFF   = 2;
    localparam int EN_ABS    = 3;
    localparam int EN_SQ_PP  = 4;
    localparam int EN_SQ     = 5;
    localparam int EN_SUM    = 6;

    // Edge order: ux uy uz vx vy vz. Products pair up as terms of one component.
    localparam int OPA [dtf_pkg::NUM_EDGE] = '{1, 2, 2, 0, 0, 1};
    localparam int OPB [dtf_pkg::NUM_EDGE] = '{5, 4, 3, 5, 4, 3};

    logic [PW-1:0]                    prod [dtf_pkg::NUM_EDGE];
    logic [dtf_pkg::NUM_EDGE-1:0]     sgn_pp_reg;
    logic [dtf_pkg::NUM_EDGE-1:0]     sgn_reg;
    logic [DSW-1:0]                   diff_next [3];
    logic [DSW-1:0]                   diff_reg  [3];
    logic [DSW-1:0]                   diff_neg  [3];
    logic [MW-1:0]                    abs_next  [3];
    logic [MW-1:0]                    abs_reg   [3];
    logic [SQW-1:0]                   sq        [3];
    logic [SUMW-1:0]                  sum_next;
    logic [SUMW-1:0]                  sum_reg;
    logic [DSW-1:0]                   term_p;
    logic [DSW-1:0]                   term_q;

    genvar g;
    generate
        for (g = 0; g < dtf_pkg::NUM_EDGE; g++)
        begin : g_prod
            dtf_umul #(.W(COORD_WIDTH)) u_mul (
                .clk    (clk),
                .en_pp  (en[EN_PP]),
                .en_sum (en[EN_PROD]),
                .a      (mag[OPA[g]]),
                .b      (mag[OPB[g]]),
                .p      (prod[g])
            );
        end
    endgenerate

    // Product signs ride alongside the multiplier stages.
    always_ff @(posedge clk)
    begin
        if (en[EN_PP])
        begin
            for (int k = 0; k < dtf_pkg::NUM_EDGE; k++)
            begin
                sgn_pp_reg[k] <= neg[OPA[k]] ^ neg[OPB[k]];
            end
        end
        if (en[EN_PROD])
        begin
            sgn_reg <= sgn_pp_reg;
        end
    end

    always_comb
    begin
        term_p = '0;
        term_q = '0;
        for (int j = 0; j < 3; j++)
        begin
            term_p = sgn_reg[2*j]   ? -{2'b00, prod[2*j]}   : {2'b00, prod[2*j]};
            term_q = sgn_reg[2*j+1] ? -{2'b00, prod[2*j+1]} : {2'b00, prod[2*j+1]};
            diff_next[j] = term_p - term_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[EN_DIFF])
        begin
            diff_reg <= diff_next;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            diff_neg[j] = -diff_reg[j];
            abs_next[j] = diff_reg[j][DSW-1] ? diff_neg[j][MW-1:0] : diff_reg[j][MW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[EN_ABS])
        begin
            abs_reg <= abs_next;
        end
    end

    generate
        for (g = 0; g < 3; g++)
        begin : g_square
            dtf_umul #(.W(MW)) u_sq (
                .clk    (clk),
                .en_pp  (en[EN_SQ_PP]),
                .en_sum (en[EN_SQ]),
                .a      (abs_reg[g]),
                .b      (abs_reg[g]),
                .p      (sq[g])
            );
        end
    endgenerate

    always_comb
    begin
        sum_next = {{(SUMW-SQW){1'b0}}, sq[0]}
                 + {{(SUMW-SQW){1'b0}}, sq[1]}
                 + {{(SUMW-SQW){1'b0}}, sq[2]};
    end

    always_ff @(posedge clk)
    begin
        if (en[EN_SUM])
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ----- rtl/degenerate_triangle_filter.sv -----
// Degenerate triangle filter: index checks and exact cross-product area test.
// Throughput: one item per cycle; each stage holds under backpressure and fills bubbles.
// The wide multiplies are split into half-width partial products, two stages each.
// Reset clears all valid bits; vertex_count resets to 0 and area_threshold to 184467.
module degenerate_triangle_filter #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // index_a, index_b, index_c, ax, ay, az, bx, by_coord, bz, cx_coord, cy_coord,
    // cz_coord, then zero fill to a whole byte
    input  logic [((3*dtf_pkg::IDX_WIDTH + 9*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // keep, reject_reason, then zero fill
    output logic [dtf_pkg::OUT_TDATA_WIDTH-1:0]   m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dtf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [dtf_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    localparam int NS    = dtf_pkg::NUM_STAGES;
    localparam int IW    = dtf_pkg::IDX_WIDTH;
    localparam int SUMW  = 4 * COORD_WIDTH + 4;
    localparam int TW    = dtf_pkg::THR_WIDTH;

    logic [IW-1:0]                  vertex_count_reg;
    logic [TW-1:0]                  area_threshold_reg;

    logic [NS:1]                    v_reg;
    logic [NS:1]                    v_in;
    logic [NS:1]                    en;

    logic [COORD_WIDTH-1:0]         coord [dtf_pkg::NUM_COORD];
    logic [COORD_WIDTH:0]           edge_diff [dtf_pkg::NUM_EDGE];
    logic [COORD_WIDTH:0]           edge_neg  [dtf_pkg::NUM_EDGE];
    logic [COORD_WIDTH-1:0]         mag_next [dtf_pkg::NUM_EDGE];
    logic [COORD_WIDTH-1:0]         mag_reg  [dtf_pkg::NUM_EDGE];
    logic [dtf_pkg::NUM_EDGE-1:0]   neg_next;
    logic [dtf_pkg::NUM_EDGE-1:0]   neg_reg;

    dtf_pkg::idx_status_t           idx_status;
    dtf_pkg::reason_t               reason_first;
    dtf_pkg::reason_t               reason_reg [NS-1:1];
    dtf_pkg::reason_t               reason_out_next;
    dtf_pkg::reason_t               reason_out_reg;
    logic [SUMW-1:0]                area_sum;

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg   <= dtf_pkg::VERTEX_COUNT_RESET;
            area_threshold_reg <= dtf_pkg::AREA_THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == dtf_pkg::CFG_VERTEX_COUNT)
            begin
                vertex_count_reg <= cfg_data[IW-1:0];
            end
            else if (cfg_index == dtf_pkg::CFG_AREA_THRESHOLD)
            begin
                area_threshold_reg <= cfg_data[TW-1:0];
            end
        end
    end

    // Pipeline control: a stage loads when it is empty or its item moves on.
    always_comb
    begin
        en[NS] = !v_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign v_in     = {v_reg[NS-1:1], s_tvalid};
    assign s_tready = en[1];
    assign m_tvalid = v_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    // Stage 1: index checks and edge vectors as magnitude and sign
    dtf_idx_check u_idx_check (
        .index_a      (s_tdata[0 +: IW]),
        .index_b      (s_tdata[IW +: IW]),
        .index_c      (s_tdata[2*IW +: IW]),
        .vertex_count (vertex_count_reg),
        .status       (idx_status)
    );

    always_comb
    begin
        if (idx_status.repeated)
        begin
            reason_first = dtf_pkg::REASON_REPEAT;
        end
        else if (idx_status.out_of_range)
        begin
            reason_first = dtf_pkg::REASON_RANGE;
        end
        else
        begin
            reason_first = dtf_pkg::REASON_KEEP;
        end
    end

    always_comb
    begin
        for (int i = 0; i < dtf_pkg::NUM_COORD; i++)
        begin
            coord[i] = s_tdata[dtf_pkg::NUM_IDX*IW + i*COORD_WIDTH +: COORD_WIDTH];
        end
        // u = b - a, v = c - a
        for (int k = 0; k < dtf_pkg::NUM_EDGE; k++)
        begin
            edge_diff[k] = {coord[k+3][COORD_WIDTH-1], coord[k+3]}
                         - {coord[k%3][COORD_WIDTH-1], coord[k%3]};
            edge_neg[k]  = -edge_diff[k];
            neg_next[k]  = edge_diff[k][COORD_WIDTH];
            mag_next[k]  = edge_diff[k][COORD_WIDTH] ? edge_neg[k][COORD_WIDTH-1:0]
                                                     : edge_diff[k][COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            reason_reg[1] <= reason_first;
        end
        for (int k = 2; k <= NS - 1; k++)
        begin
            if (en[k])
            begin
                reason_reg[k] <= reason_reg[k-1];
            end
        end
    end

    // Stages 2 to 8
    dtf_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
        .clk (clk),
        .en  (en[NS-1:2]),
        .mag (mag_reg),
        .neg (neg_reg),
        .sum (area_sum)
    );

    // Stage 9: area compare and output register
    always_comb
    begin
        if (reason_reg[NS-1] != dtf_pkg::REASON_KEEP)
        begin
            reason_out_next = reason_reg[NS-1];
        end
        else if ((area_sum[SUMW-1:TW] == '0) && (area_sum[TW-1:0] < area_threshold_reg))
        begin
            reason_out_next = dtf_pkg::REASON_AREA;
        end
        else
        begin
            reason_out_next = dtf_pkg::REASON_KEEP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS])
        begin
            reason_out_reg <= reason_out_next;
        end
    end

    assign m_tdata = {{(dtf_pkg::OUT_TDATA_WIDTH-3){1'b0}}, reason_out_reg,
                      (reason_out_reg == dtf_pkg::REASON_KEEP)};

endmodule
